FILE: hw/rtl/uart_tx_ring_queue_parity_assert.svh
// Assertion macros used by the queue control RTL.
`ifndef UART_TX_RING_QUEUE_PARITY_ASSERT_SVH
`define UART_TX_RING_QUEUE_PARITY_ASSERT_SVH

// Condition a in one cycle implies condition c in the next cycle.
`define UTRQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("queue assertion failed: next-cycle implication");

// Condition c holds at every clock edge outside reset.
`define UTRQ_ASSERT_ALWAYS(label, clk, rst_n, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
		else $error("queue assertion failed: invariant");

`endif

FILE: hw/rtl/utrq_pkg.sv
package utrq_pkg;

	// Default ring size in byte slots.
	localparam int UTRQ_DEPTH_DEF = 64;

	// Width of the fill level result field.
	localparam int FILL_W = 6;

	// Request kinds carried in the slave tuser.
	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_READY = 1'b1;

	// Ninth bit rules.
	typedef enum logic [1:0] {
		PAR_ONE  = 2'd0,
		PAR_ZERO = 2'd1,
		PAR_EVEN = 2'd2,
		PAR_ODD  = 2'd3
	} parity_mode_t;

	localparam parity_mode_t PAR_RESET = PAR_EVEN;

	// Control results of one item, handed from the queue control to the output stage.
	typedef struct packed {
		logic              accepted;
		logic              pop;
		logic              finished;
		logic              drain;
		logic [FILL_W-1:0] fill;
	} utrq_res_t;

endpackage

FILE: hw/rtl/utrq_ring.sv
module utrq_ring
	import utrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = UTRQ_DEPTH_DEF,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [PTR_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [PTR_W-1:0] rd_addr,
	output logic [7:0]       rd_data_s1
);

	logic [7:0] mem [QUEUE_DEPTH];

	// Write port: one byte slot per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/utrq_ctrl.sv
module utrq_ctrl
	import utrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = UTRQ_DEPTH_DEF,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_kind,
	input  logic [7:0]       in_byte,
	input  logic             in_idle,
	input  logic             s1_adv,
	output logic             s1_valid,
	output utrq_res_t        s1_res,
	output logic             mem_wr_en,
	output logic [PTR_W-1:0] mem_wr_addr,
	output logic [7:0]       mem_wr_data,
	output logic             mem_rd_en,
	output logic [PTR_W-1:0] mem_rd_addr
);

	`include "uart_tx_ring_queue_parity_assert.svh"

	localparam int CNT_W = PTR_W + 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] wr_q, rd_q;
	logic             drain_q, fin_q;
	logic             s1_valid_q;
	utrq_res_t        res_s1;

	logic             accept, is_add, full, empty;
	logic [PTR_W-1:0] wr_nxt_slot, rd_nxt_slot;
	logic [PTR_W-1:0] wr_d, rd_d;
	logic             drain_d, fin_d, acc_d, pop_d;
	logic [CNT_W-1:0] fill_cnt;
	logic [FILL_W-1:0] fill_d;

	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;
	assign is_add   = (in_kind == REQ_ADD);

	// Ring neighbors and occupancy tests.
	assign wr_nxt_slot = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
	assign rd_nxt_slot = (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
	assign full  = (wr_nxt_slot == rd_q);
	assign empty = (wr_q == rd_q);

	// Next queue state for the item at the input.
	always_comb begin
		wr_d    = wr_q;
		rd_d    = rd_q;
		drain_d = drain_q;
		fin_d   = fin_q;
		acc_d   = 1'b0;
		pop_d   = 1'b0;
		if (is_add) begin
			if (!full) begin
				wr_d  = wr_nxt_slot;
				acc_d = 1'b1;
				if (in_idle && !drain_q) begin
					drain_d = 1'b1;
					fin_d   = 1'b0;
				end
			end
		end else begin
			if (empty) begin
				drain_d = 1'b0;
				fin_d   = 1'b1;
			end else begin
				rd_d  = rd_nxt_slot;
				pop_d = 1'b1;
			end
		end
	end

	// Bytes waiting after this item.
	always_comb begin
		if (wr_d >= rd_d) begin
			fill_cnt = {1'b0, wr_d} - {1'b0, rd_d};
		end else begin
			fill_cnt = {1'b0, wr_d} + DEPTH_CNT - {1'b0, rd_d};
		end
	end

	generate
		if (CNT_W >= FILL_W) begin : g_fill_trunc
			assign fill_d = fill_cnt[FILL_W-1:0];
		end else begin : g_fill_ext
			assign fill_d = {{(FILL_W - CNT_W){1'b0}}, fill_cnt};
		end
	endgenerate

	// Memory access happens at the edge that takes the item.
	assign mem_wr_en   = accept && acc_d;
	assign mem_wr_addr = wr_q;
	assign mem_wr_data = in_byte;
	assign mem_rd_en   = accept && pop_d;
	assign mem_rd_addr = rd_q;

	// Queue state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			drain_q <= 1'b0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			wr_q    <= wr_d;
			rd_q    <= rd_d;
			drain_q <= drain_d;
			fin_q   <= fin_d;
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Stage one result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.accepted <= acc_d;
			res_s1.pop      <= pop_d;
			res_s1.finished <= fin_d;
			res_s1.drain    <= drain_d;
			res_s1.fill     <= fill_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_res   = res_s1;

	// The pointers stay inside the ring.
	`UTRQ_ASSERT_ALWAYS(a_ptr_range, clk, arst_n, (wr_q <= LAST_SLOT) && (rd_q <= LAST_SLOT))
	// An add on a full ring is refused and leaves the write pointer alone.
	`UTRQ_ASSERT_NEXT(a_full_reject, clk, arst_n, accept && is_add && full,
		s1_valid_q && !res_s1.accepted && $stable(wr_q))
	// A ready item on an empty ring stops draining and pops nothing.
	`UTRQ_ASSERT_NEXT(a_empty_ready, clk, arst_n, accept && !is_add && empty,
		!res_s1.pop && res_s1.finished && !res_s1.drain && $stable(rd_q))
	// A stalled stage one keeps its result.
	`UTRQ_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_q && !s1_adv,
		s1_valid_q && $stable(res_s1))

endmodule

FILE: hw/rtl/utrq_out.sv
module utrq_out
	import utrq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s1_valid,
	input  utrq_res_t    s1_res,
	input  logic [7:0]   rd_data_s1,
	input  parity_mode_t mode,
	output logic         s1_adv,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [23:0]  out_data
);

	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic [7:0]  byte_d;
	logic        par_d;

	assign s1_adv = !out_valid_q || out_ready;

	// The popped byte, zero when nothing leaves the ring.
	assign byte_d = s1_res.pop ? rd_data_s1 : 8'h00;

	// Ninth bit by the selected rule.
	always_comb begin
		unique case (mode)
			PAR_ONE:  par_d = 1'b1;
			PAR_ZERO: par_d = 1'b0;
			PAR_EVEN: par_d = ^byte_d;
			PAR_ODD:  par_d = ~^byte_d;
			default:  par_d = 1'b0;
		endcase
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			out_data_q <= {5'd0, s1_res.fill, s1_res.drain, s1_res.finished,
				par_d && s1_res.pop, byte_d, s1_res.pop, s1_res.accepted};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hw/rtl/uart_tx_ring_queue_parity.sv
// UART transmit ring queue with a ninth parity bit.
// Slave channel: one item per handshake; s_tuser selects an add (0) or a
// transmitter-ready event (1). An add stores the byte unless the ring is full,
// in which case it is refused and reported through the accepted bit.
// Master channel: exactly one result item for every input item, in order,
// carrying accepted, the popped byte with its ninth bit, the finished and
// drain flags and the fill level after the item.
// Configuration channel: cfg_data sets the ninth-bit rule (one, zero, even,
// odd); cfg_ready is always high. Write it only while the block is idle.
// Pipeline: an item is registered in stage one, then in the result register.
// Throughput: one item per cycle while m_tready stays high, set by the single
// write port and registered read port of the ring memory.
// Reset: the ring is empty, both flags are clear and the rule is even parity.
// The ring contents need no clearing, since only written slots are read.
// Stall: when m_tready is low the result register and stage one hold, and
// s_tready drops once both are occupied; nothing is lost or repeated.
module uart_tx_ring_queue_parity
	import utrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = UTRQ_DEPTH_DEF,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [8] tx_idle, [15:9] zero
	input  logic        s_tuser,  // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [0] accepted, [1] tx_valid, [9:2] tx_byte,
	                              // [10] tx_parity_bit, [11] queue_finished,
	                              // [12] drain_enabled, [18:13] fill_level, [23:19] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);

	parity_mode_t     mode_q;
	logic             s1_adv, s1_valid;
	utrq_res_t        s1_res;
	logic [7:0]       rd_data_s1;
	logic             mem_wr_en, mem_rd_en;
	logic [PTR_W-1:0] mem_wr_addr, mem_rd_addr;
	logic [7:0]       mem_wr_data;

	assign cfg_ready = 1'b1;

	// Parity rule register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= parity_mode_t'(cfg_data);
		end
	end

	utrq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_byte    (s_tdata[7:0]),
		.in_idle    (s_tdata[8]),
		.s1_adv     (s1_adv),
		.s1_valid   (s1_valid),
		.s1_res     (s1_res),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr)
	);

	utrq_ring #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (mem_rd_en),
		.rd_addr   (mem_rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	utrq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_res    (s1_res),
		.rd_data_s1(rd_data_s1),
		.mode      (mode_q),
		.s1_adv    (s1_adv),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

FILE: test/uart_tx_ring_queue_parity_tb.sv
`timescale 1ns / 1ps

module uart_tx_ring_queue_parity_tb;
	import utrq_pkg::*;

	localparam int RING_PTR_W = $clog2(UTRQ_DEPTH_DEF);
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 190;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 300;

	// One request toward the queue: an add of a byte or a transmitter-ready event.
	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic       idle;
	} queue_req_t;

	// One result item as the block reports it.
	typedef struct packed {
		logic                accepted;
		logic                tx_valid;
		logic [7:0]          tx_byte;
		logic                tx_parity;
		logic                finished;
		logic                drain;
		logic [FILL_W-1:0]   fill;
	} queue_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = '0;

	uart_tx_ring_queue_parity dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the ring and its flags.
	logic [7:0]            shadow_ring [UTRQ_DEPTH_DEF];
	logic [RING_PTR_W-1:0] shadow_wr = '0;
	logic [RING_PTR_W-1:0] shadow_rd = '0;
	logic                  shadow_drain = 1'b0;
	logic                  shadow_finished = 1'b0;
	parity_mode_t          shadow_mode = PAR_RESET;

	queue_req_t pending_reqs [$];
	queue_res_t expected_res [$];

	int  fail_count = 0;
	int  items_issued = 0;
	int  results_seen = 0;
	int  add_pct [NUM_PHASES] = '{85, 30, 55, 92, 20, 50, 70, 50};
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one request to the shadow queue and return the result it causes.
	function automatic queue_res_t ring_step(logic kind, logic [7:0] data, logic idle);
		queue_res_t            r;
		logic [RING_PTR_W-1:0] next_wr;
		r = '0;
		next_wr = shadow_wr + 1'b1;
		if (kind == REQ_ADD) begin
			if (next_wr != shadow_rd) begin
				shadow_ring[shadow_wr] = data;
				shadow_wr = next_wr;
				r.accepted = 1'b1;
				if (idle && !shadow_drain) begin
					shadow_drain = 1'b1;
					shadow_finished = 1'b0;
				end
			end
		end else if (shadow_rd == shadow_wr) begin
			shadow_drain = 1'b0;
			shadow_finished = 1'b1;
		end else begin
			r.tx_valid = 1'b1;
			r.tx_byte = shadow_ring[shadow_rd];
			case (shadow_mode)
				PAR_ONE:  r.tx_parity = 1'b1;
				PAR_ZERO: r.tx_parity = 1'b0;
				PAR_EVEN: r.tx_parity = ^r.tx_byte;
				default:  r.tx_parity = ~^r.tx_byte;
			endcase
			shadow_rd = shadow_rd + 1'b1;
		end
		r.finished = shadow_finished;
		r.drain = shadow_drain;
		r.fill = shadow_wr - shadow_rd;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Predict on every accepted request and compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		queue_res_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			cfg_taken <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready)
				shadow_mode = parity_mode_t'(cfg_data);
			if (s_tvalid && s_tready)
				expected_res.push_back(ring_step(s_tuser, s_tdata[7:0], s_tdata[8]));
			if (m_tvalid && m_tready) begin
				if (expected_res.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %0h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = expected_res.pop_front();
					results_seen++;
					check_field("accepted", want.accepted, m_tdata[0]);
					check_field("tx_valid", want.tx_valid, m_tdata[1]);
					check_field("tx_byte", want.tx_byte, m_tdata[9:2]);
					check_field("tx_parity_bit", want.tx_parity, m_tdata[10]);
					check_field("queue_finished", want.finished, m_tdata[11]);
					check_field("drain_enabled", want.drain, m_tdata[12]);
					check_field("fill_level", want.fill, m_tdata[18:13]);
				end
			end
		end
	end

	// Request driver: holds an item until it is taken, with random gaps between items.
	always @(negedge clk) begin
		queue_req_t cur;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				cur = pending_reqs.pop_front();
				s_tdata <= {7'd0, cur.idle, cur.data};
				s_tuser <= cur.kind;
				s_tvalid <= 1'b1;
				if (!send_calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 14);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold that backs up the queue.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!recv_calm && $urandom_range(0, 7) == 0)
				recv_gap = $urandom_range(1, 14);
		end
	end

	// Watchdog: too many cycles in a row with no item moving on any channel.
	always @(posedge clk) begin
		int quiet_cycles;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus: directed requests, then random phases under different parity rules.
	initial begin
		queue_req_t   req;
		parity_mode_t mode_plan [NUM_PHASES];
		int           p;
		int           i;
		mode_plan = '{PAR_ONE, PAR_ODD, PAR_ZERO, PAR_EVEN, PAR_ODD, PAR_ONE,
			parity_mode_t'($urandom_range(0, 3)), PAR_ZERO};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset rule: ready on an empty ring, the drain
		// and finished flags, extreme bytes, and pops while draining is off.
		pending_reqs.push_back('{REQ_READY, 8'h00, 1'b1});
		pending_reqs.push_back('{REQ_ADD, 8'h00, 1'b0});
		pending_reqs.push_back('{REQ_ADD, 8'hFF, 1'b1});
		pending_reqs.push_back('{REQ_ADD, 8'h01, 1'b1});
		pending_reqs.push_back('{REQ_ADD, 8'h80, 1'b0});
		pending_reqs.push_back('{REQ_ADD, 8'h7F, 1'b1});
		repeat (6) pending_reqs.push_back('{REQ_READY, 8'hFF, 1'b0});
		pending_reqs.push_back('{REQ_ADD, 8'hA5, 1'b0});
		pending_reqs.push_back('{REQ_ADD, 8'h5A, 1'b0});
		repeat (3) pending_reqs.push_back('{REQ_READY, 8'h00, 1'b0});
		items_issued += pending_reqs.size();

		for (p = 0; p < NUM_PHASES; p++) begin
			// The rule changes only once every result of the last phase is in.
			while (results_seen != items_issued)
				@(negedge clk);
			repeat (4) @(negedge clk);
			cfg_data <= mode_plan[p];
			cfg_valid <= 1'b1;
			@(negedge clk);
			while (!cfg_taken)
				@(negedge clk);
			cfg_valid <= 1'b0;

			send_calm = (p % 3 == 2) || (p == NUM_PHASES - 1);
			recv_calm = (p % 4 == 1) || (p == NUM_PHASES - 1);
			if (p == 3)
				hold_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				req.kind = ($urandom_range(0, 99) < add_pct[p]) ? REQ_ADD : REQ_READY;
				req.data = $urandom_range(0, 255);
				req.idle = $urandom_range(0, 1);
				pending_reqs.push_back(req);
				items_issued++;
			end
		end

		while (results_seen != items_issued)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && expected_res.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
